/* src/bell_shaped_activation_interval_detector_top_assert.svh */
// Assertion macros used by the detector top level.
`ifndef BELL_SHAPED_ACTIVATION_INTERVAL_DETECTOR_TOP_ASSERT_SVH
`define BELL_SHAPED_ACTIVATION_INTERVAL_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on the rising edge of clk, off while rst_n is low.
`define BSAID_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define BSAID_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSAID_ASSERT(lbl, prop, msg)
`define BSAID_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/bsaid_pkg.sv */
// Types, constants and event codes of the activation interval detector.
package bsaid_pkg;

    localparam int MODEL_W  = 4;
    localparam int SAMPLE_W = 32;
    localparam int SCORE_W  = 16;
    localparam int RISE_W   = 16;
    localparam int EVENT_W  = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int NUM_MODELS_DEF = 16;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE         = 3'd0;
    localparam logic [EVENT_W-1:0] EV_OPENED       = 3'd1;
    localparam logic [EVENT_W-1:0] EV_EXTENDED     = 3'd2;
    localparam logic [EVENT_W-1:0] EV_NOT_SMOOTH   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_ASYMMETRIC   = 3'd4;
    localparam logic [EVENT_W-1:0] EV_COMPLETE     = 3'd5;
    localparam logic [EVENT_W-1:0] EV_CLOSED_QUICK = 3'd6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_MODE     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUICK_THRESHOLD = 4'd1;

    localparam logic              MODE_BELL          = 1'b0;
    localparam logic [SCORE_W-1:0] QUICK_THRESHOLD_RST = 16'd52429;  // 0.8 in Q0.16

    localparam logic signed [RISE_W-1:0] RISE_MAX = 16'sh7FFF;
    localparam logic signed [RISE_W-1:0] RISE_MIN = -16'sh8000;

    typedef struct packed {
        logic [SAMPLE_W-1:0]      start_sample;
        logic [SAMPLE_W-1:0]      end_sample;
        logic [SCORE_W-1:0]       peak_value;
        logic [SCORE_W-1:0]       reference_value;
        logic signed [RISE_W-1:0] rise_count;
    } rec_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_kind;
        rec_t               rec;
        logic               open_next;
        logic [SCORE_W-1:0] rep;
    } upd_t;

endpackage

/* src/bsaid_rec_ram.sv */
// Per-model interval record memory, one write and one registered read port.
module bsaid_rec_ram #(
    parameter int DEPTH = bsaid_pkg::NUM_MODELS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  bsaid_pkg::rec_t   wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output bsaid_pkg::rec_t   rd_data
);
    import bsaid_pkg::*;

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/bsaid_update.sv */
// Record update and event decision for one score.
module bsaid_update (
    input  bsaid_pkg::rec_t                     rec,
    input  logic                                is_open,
    input  logic                                in_range,
    input  logic                                detect_mode,
    input  logic [bsaid_pkg::SCORE_W-1:0]       quick_threshold,
    input  logic [bsaid_pkg::SAMPLE_W-1:0]      sample_number,
    input  logic [bsaid_pkg::SCORE_W-1:0]       score_now,
    input  logic [bsaid_pkg::SCORE_W-1:0]       score_before,
    output bsaid_pkg::upd_t                     upd
);
    import bsaid_pkg::*;

    rec_t                     opened;
    logic signed [RISE_W-1:0] rise_inc;
    logic signed [RISE_W-1:0] rise_dec;
    logic                     rough;
    logic                     asym;
    logic                     done;

    always_comb
    begin
        opened.start_sample    = sample_number;
        opened.end_sample      = '0;
        opened.peak_value      = score_now;
        opened.reference_value = score_before;
        opened.rise_count      = RISE_W'(1);

        rise_inc = (rec.rise_count != RISE_MAX) ? rec.rise_count + RISE_W'(1) : rec.rise_count;
        rise_dec = (rec.rise_count != RISE_MIN) ? rec.rise_count - RISE_W'(1) : rec.rise_count;
        rough = score_now > score_before;
        asym  = (rise_dec == '0) && (score_now < rec.reference_value);
        done  = !rise_dec[RISE_W-1] && (score_now == rec.reference_value);
    end

    always_comb
    begin
        upd.event_kind = EV_NONE;
        upd.rec        = rec;
        upd.open_next  = is_open;
        upd.rep        = '0;
        if (in_range)
        begin
            if (detect_mode == MODE_BELL)
            begin
                if (score_now != '0)
                begin
                    if (!is_open)
                    begin
                        upd.rec        = opened;
                        upd.open_next  = 1'b1;
                        upd.event_kind = EV_OPENED;
                    end
                    else if (score_now >= rec.peak_value)
                    begin
                        upd.rec.end_sample = sample_number;
                        upd.rec.peak_value = score_now;
                        upd.rec.rise_count = rise_inc;
                        upd.event_kind     = EV_EXTENDED;
                    end
                    else
                    begin
                        // falling: report beats rough beats asymmetric
                        upd.rec.rise_count = rise_dec;
                        if (done)
                        begin
                            upd.event_kind = EV_COMPLETE;
                            upd.open_next  = 1'b0;
                        end
                        else if (rough)
                        begin
                            upd.event_kind = EV_NOT_SMOOTH;
                            upd.open_next  = 1'b0;
                        end
                        else if (asym)
                        begin
                            upd.event_kind = EV_ASYMMETRIC;
                            upd.open_next  = 1'b0;
                        end
                    end
                end
                else if (is_open && rec.reference_value == '0)
                begin
                    upd.event_kind = EV_COMPLETE;
                    upd.open_next  = 1'b0;
                end
            end
            else
            begin
                if (score_now > quick_threshold)
                begin
                    if (!is_open)
                    begin
                        upd.rec        = opened;
                        upd.open_next  = 1'b1;
                        upd.event_kind = EV_OPENED;
                    end
                    else
                    begin
                        upd.rec.end_sample = sample_number;
                        if (score_now >= rec.peak_value)
                        begin
                            upd.rec.peak_value = score_now;
                        end
                        upd.event_kind = EV_EXTENDED;
                    end
                    upd.rep = score_now;
                end
                else if (is_open)
                begin
                    upd.event_kind = EV_CLOSED_QUICK;
                    upd.open_next  = 1'b0;
                end
            end
        end
    end

endmodule

/* src/bell_shaped_activation_interval_detector_top.sv */
// Top level of the bell-shaped activation interval detector.
// Takes one score per cycle while the output side is ready and returns one event per
// score, registered through the update stage and then the output register. The
// per-model records sit in a RAM with a registered read; the read is issued as a
// score is taken, the update happens in the following cycle and writes back as the
// item leaves the update stage. A score for the same model as the one just ahead
// of it picks up that record through a bypass register; open flags are flip-flops
// cleared by reset, so no clearing pass is needed. Output stalls hold the pipeline.
`include "bell_shaped_activation_interval_detector_top_assert.svh"

module bell_shaped_activation_interval_detector_top #(
    parameter int NUM_MODELS = bsaid_pkg::NUM_MODELS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [bsaid_pkg::MODEL_W-1:0]        model_index,
    input  logic [bsaid_pkg::SAMPLE_W-1:0]       sample_number,
    input  logic [bsaid_pkg::SCORE_W-1:0]        score_now,
    input  logic [bsaid_pkg::SCORE_W-1:0]        score_before,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bsaid_pkg::EVENT_W-1:0]        event_kind,
    output logic [bsaid_pkg::MODEL_W-1:0]        model_out,
    output logic [bsaid_pkg::SAMPLE_W-1:0]       interval_start,
    output logic [bsaid_pkg::SAMPLE_W-1:0]       interval_end,
    output logic [bsaid_pkg::SCORE_W-1:0]        peak_score,
    output logic [bsaid_pkg::SCORE_W-1:0]        reported_score,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bsaid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bsaid_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bsaid_pkg::*;

    localparam int MIDX_W = (NUM_MODELS > 1) ? $clog2(NUM_MODELS) : 1;

    // configuration
    logic               detect_mode_reg;
    logic [SCORE_W-1:0] quick_threshold_reg;

    // open flags
    logic open_reg [NUM_MODELS];

    // update stage
    logic                s1_valid_reg;
    logic [MIDX_W-1:0]   s1_idx_reg;
    logic [MODEL_W-1:0]  s1_model_reg;
    logic                s1_in_range_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [SCORE_W-1:0]  s1_score_reg;
    logic [SCORE_W-1:0]  s1_before_reg;

    // bypass of the record written as the current item was read
    logic fwd_hit_reg;
    rec_t fwd_rec_reg;

    // output register
    logic                out_valid_reg;
    logic [EVENT_W-1:0]  event_kind_reg;
    logic [MODEL_W-1:0]  model_out_reg;
    logic [SAMPLE_W-1:0] interval_start_reg;
    logic [SAMPLE_W-1:0] interval_end_reg;
    logic [SCORE_W-1:0]  peak_score_reg;
    logic [SCORE_W-1:0]  reported_score_reg;

    logic                  in_fire;
    logic                  s1_adv;
    logic                  s1_fire;
    logic                  s1_wr;
    logic [MIDX_W+MODEL_W-1:0] in_idx_wide;
    logic [MIDX_W-1:0]     in_idx;
    logic                  in_range;
    rec_t                  ram_rd;
    rec_t                  cur_rec;
    logic                  cur_open;
    upd_t                  upd;
    logic                  s1_valid_next;
    logic                  out_valid_next;

    assign in_idx_wide = {{MIDX_W{1'b0}}, model_index};
    assign in_idx      = in_idx_wide[MIDX_W-1:0];
    assign in_range    = 32'(model_index) < NUM_MODELS;

    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign s1_wr    = s1_fire && s1_in_range_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_mode_reg     <= MODE_BELL;
            quick_threshold_reg <= QUICK_THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DETECT_MODE:     detect_mode_reg     <= cfg_data[0];
                CFG_QUICK_THRESHOLD: quick_threshold_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    bsaid_rec_ram #(
        .DEPTH (NUM_MODELS),
        .AW    (MIDX_W)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (s1_wr),
        .wr_addr (s1_idx_reg),
        .wr_data (upd.rec),
        .rd_en   (in_fire),
        .rd_addr (in_idx),
        .rd_data (ram_rd)
    );

    assign cur_rec  = fwd_hit_reg ? fwd_rec_reg : ram_rd;
    assign cur_open = s1_in_range_reg && open_reg[s1_idx_reg];

    bsaid_update u_update (
        .rec             (cur_rec),
        .is_open         (cur_open),
        .in_range        (s1_in_range_reg),
        .detect_mode     (detect_mode_reg),
        .quick_threshold (quick_threshold_reg),
        .sample_number   (s1_sample_reg),
        .score_now       (s1_score_reg),
        .score_before    (s1_before_reg),
        .upd             (upd)
    );

    always_comb
    begin
        s1_valid_next  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            for (int i = 0; i < NUM_MODELS; i++)
            begin
                open_reg[i] <= 1'b0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                fwd_hit_reg <= s1_wr && (s1_idx_reg == in_idx);
            end
            if (s1_wr)
            begin
                open_reg[s1_idx_reg] <= upd.open_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_idx_reg      <= in_idx;
            s1_model_reg    <= model_index;
            s1_in_range_reg <= in_range;
            s1_sample_reg   <= sample_number;
            s1_score_reg    <= score_now;
            s1_before_reg   <= score_before;
            fwd_rec_reg     <= upd.rec;
        end
        if (s1_fire)
        begin
            event_kind_reg <= upd.event_kind;
            model_out_reg  <= s1_model_reg;
            if (upd.event_kind != EV_NONE)
            begin
                interval_start_reg <= upd.rec.start_sample;
                interval_end_reg   <= upd.rec.end_sample;
                peak_score_reg     <= upd.rec.peak_value;
                reported_score_reg <= upd.rep;
            end
            else
            begin
                interval_start_reg <= '0;
                interval_end_reg   <= '0;
                peak_score_reg     <= '0;
                reported_score_reg <= '0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = event_kind_reg;
    assign model_out      = model_out_reg;
    assign interval_start = interval_start_reg;
    assign interval_end   = interval_end_reg;
    assign peak_score     = peak_score_reg;
    assign reported_score = reported_score_reg;

    `BSAID_ASSERT(a_s1_hold, s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_idx_reg), "update stage lost or changed a stalled item")
    `BSAID_ASSERT(a_none_zero, out_valid_reg && event_kind_reg == EV_NONE |-> interval_start_reg == '0 && peak_score_reg == '0 && reported_score_reg == '0, "event none with nonzero fields")
    `BSAID_ASSERT(a_close_clears, s1_wr && !upd.open_next |=> !open_reg[$past(s1_idx_reg)], "open flag not cleared on close")
    `BSAID_ASSERT(a_fwd_valid, fwd_hit_reg && !s1_valid_reg |=> !s1_valid_reg || !$past(in_fire) || fwd_hit_reg == $past(s1_wr && (s1_idx_reg == in_idx)), "bypass flag out of step")
    `BSAID_ASSERT_ALWAYS(a_stall_cause, !in_ready |-> s1_valid_reg && out_valid_reg, "input stalled without a full pipeline")

endmodule

/* test/bell_shaped_activation_interval_detector_top_tb.sv */
// Self-checking testbench for the activation interval detector: table and random runs.
module bell_shaped_activation_interval_detector_top_tb;
    import bsaid_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic MODE_QUICK = ~MODE_BELL;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_QUICK_THRESHOLD + 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPARE = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic [EVENT_W-1:0]  kind;
        logic [MODEL_W-1:0]  model;
        logic [SAMPLE_W-1:0] start;
        logic [SAMPLE_W-1:0] stop;
        logic [SCORE_W-1:0]  peak;
        logic [SCORE_W-1:0]  rep;
    } interval_event_t;

    typedef enum logic [1:0] {ROW_SCORE, ROW_TYPED, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [MODEL_W-1:0]    model;
        logic [SAMPLE_W-1:0]   sample;
        logic [SCORE_W-1:0]    now;
        logic [SCORE_W-1:0]    prev;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        interval_event_t       want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid;
    logic in_ready;
    logic [MODEL_W-1:0] model_index;
    logic [SAMPLE_W-1:0] sample_number;
    logic [SCORE_W-1:0] score_now;
    logic [SCORE_W-1:0] score_before;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [EVENT_W-1:0] event_kind;
    logic [MODEL_W-1:0] model_out;
    logic [SAMPLE_W-1:0] interval_start;
    logic [SAMPLE_W-1:0] interval_end;
    logic [SCORE_W-1:0] peak_score;
    logic [SCORE_W-1:0] reported_score;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor copy of configuration and per-model records
    logic cfg_mode = MODE_BELL;
    logic [SCORE_W-1:0] cfg_threshold = QUICK_THRESHOLD_RST;
    logic rec_open [NUM_MODELS_DEF];
    logic [SAMPLE_W-1:0] rec_start [NUM_MODELS_DEF];
    logic [SAMPLE_W-1:0] rec_stop [NUM_MODELS_DEF];
    logic [SCORE_W-1:0] rec_peak [NUM_MODELS_DEF];
    logic [SCORE_W-1:0] rec_ref [NUM_MODELS_DEF];
    logic signed [RISE_W-1:0] rec_rise [NUM_MODELS_DEF];

    // per-model bell generator for the random traffic
    int gen_level [NUM_MODELS_DEF];
    int gen_ref [NUM_MODELS_DEF];
    int gen_goal [NUM_MODELS_DEF];
    int gen_rises [NUM_MODELS_DEF];
    int gen_left [NUM_MODELS_DEF];
    int gen_floor [NUM_MODELS_DEF];
    bit gen_active [NUM_MODELS_DEF];
    bit gen_falling [NUM_MODELS_DEF];
    logic [SAMPLE_W-1:0] gen_sample [NUM_MODELS_DEF];

    interval_event_t pending_events [$];
    plan_row_t plan [$];
    bit typed_pending = 1'b0;
    interval_event_t typed_want = '0;
    int mismatches = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    bell_shaped_activation_interval_detector_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .model_index    (model_index),
        .sample_number  (sample_number),
        .score_now      (score_now),
        .score_before   (score_before),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_kind     (event_kind),
        .model_out      (model_out),
        .interval_start (interval_start),
        .interval_end   (interval_end),
        .peak_score     (peak_score),
        .reported_score (reported_score),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void add_row(input plan_row_t row);
        plan.insert(plan.size(), row);
    endfunction

    function automatic void open_interval(input logic [MODEL_W-1:0] m,
            input logic [SAMPLE_W-1:0] ns, input logic [SCORE_W-1:0] now, prev);
        rec_open[m] = 1'b1;
        rec_start[m] = ns;
        rec_stop[m] = '0;
        rec_peak[m] = now;
        rec_ref[m] = prev;
        rec_rise[m] = 1;
    endfunction

    function automatic interval_event_t track_interval(input logic [MODEL_W-1:0] m,
            input logic [SAMPLE_W-1:0] ns, input logic [SCORE_W-1:0] now, prev);
        interval_event_t ev;
        logic rough;
        logic asym;
        logic done;
        ev = '0;
        ev.kind = EV_NONE;
        ev.model = m;
        if (cfg_mode == MODE_BELL)
        begin
            if (now != 0)
            begin
                if (!rec_open[m])
                begin
                    open_interval(m, ns, now, prev);
                    ev.kind = EV_OPENED;
                end
                else if (now >= rec_peak[m])
                begin
                    rec_stop[m] = ns;
                    rec_peak[m] = now;
                    if (rec_rise[m] != RISE_MAX)
                        rec_rise[m] = rec_rise[m] + 1;
                    ev.kind = EV_EXTENDED;
                end
                else
                begin
                    if (rec_rise[m] != RISE_MIN)
                        rec_rise[m] = rec_rise[m] - 1;
                    rough = now > prev;
                    asym = (rec_rise[m] == 0) && (now < rec_ref[m]);
                    done = !rec_rise[m][RISE_W-1] && (now == rec_ref[m]);
                    // report beats rough, rough beats asymmetric
                    if (done)
                        ev.kind = EV_COMPLETE;
                    else if (rough)
                        ev.kind = EV_NOT_SMOOTH;
                    else if (asym)
                        ev.kind = EV_ASYMMETRIC;
                    if (ev.kind != EV_NONE)
                        rec_open[m] = 1'b0;
                end
            end
            else if (rec_open[m] && rec_ref[m] == 0)
            begin
                ev.kind = EV_COMPLETE;
                rec_open[m] = 1'b0;
            end
        end
        else
        begin
            if (now > cfg_threshold)
            begin
                if (!rec_open[m])
                begin
                    open_interval(m, ns, now, prev);
                    ev.kind = EV_OPENED;
                end
                else
                begin
                    rec_stop[m] = ns;
                    if (now >= rec_peak[m])
                        rec_peak[m] = now;
                    ev.kind = EV_EXTENDED;
                end
                ev.rep = now;
            end
            else if (rec_open[m])
            begin
                ev.kind = EV_CLOSED_QUICK;
                rec_open[m] = 1'b0;
            end
        end
        if (ev.kind != EV_NONE)
        begin
            ev.start = rec_start[m];
            ev.stop = rec_stop[m];
            ev.peak = rec_peak[m];
        end
        return ev;
    endfunction

    function automatic plan_row_t score_row(input logic [MODEL_W-1:0] m,
            input logic [SAMPLE_W-1:0] ns, input logic [SCORE_W-1:0] now, prev);
        plan_row_t row;
        row = '0;
        row.kind = ROW_SCORE;
        row.model = m;
        row.sample = ns;
        row.now = now;
        row.prev = prev;
        return row;
    endfunction

    function automatic plan_row_t typed_row(input logic [MODEL_W-1:0] m,
            input logic [SAMPLE_W-1:0] ns, input logic [SCORE_W-1:0] now, prev,
            input logic [EVENT_W-1:0] kind, input logic [SAMPLE_W-1:0] start, stop,
            input logic [SCORE_W-1:0] peak, rep);
        plan_row_t row;
        row = score_row(m, ns, now, prev);
        row.kind = ROW_TYPED;
        row.want.kind = kind;
        row.want.model = m;
        row.want.start = start;
        row.want.stop = stop;
        row.want.peak = peak;
        row.want.rep = rep;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
            input logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        row.reg_data = data;
        return row;
    endfunction

    task automatic compare_field(input string what, input logic [31:0] want, got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Starts and ends at a falling edge; valid stays up after the transfer.
    task automatic push_score(input logic [MODEL_W-1:0] m, input logic [SAMPLE_W-1:0] ns,
            input logic [SCORE_W-1:0] now, prev, input bit typed,
            input interval_event_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        model_index = m;
        sample_number = ns;
        score_now = now;
        score_before = prev;
        typed_pending = typed;
        typed_want = want;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain_events();
        in_valid = 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly well-formed bells per model, interleaved, with some noise.
    task automatic run_traffic(input int n_items, input int hold_at, input int pause_at);
        int m;
        int now;
        int prev;
        int last_m;
        logic [SAMPLE_W-1:0] ns;
        last_m = 0;
        for (int i = 0; i < n_items; i++)
        begin
            if (i == hold_at)
                hold_req++;
            if (i == pause_at)
                drain_events();
            if ($urandom_range(99) < 12)
            begin
                m = $urandom_range(NUM_MODELS_DEF - 1);
                ns = $urandom;
                case ($urandom_range(3))
                    0: now = 0;
                    1: now = 16'hFFFF;
                    default: now = $urandom_range(16'hFFFF);
                endcase
                prev = $urandom_range(16'hFFFF);
            end
            else
            begin
                m = ($urandom_range(99) < 40) ? last_m : $urandom_range(NUM_MODELS_DEF - 1);
                if (!gen_active[m])
                    gen_sample[m] = $urandom;
                else
                    gen_sample[m] = gen_sample[m] + 1;
                ns = gen_sample[m];
                if (!gen_active[m])
                begin
                    gen_ref[m] = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 20000);
                    prev = gen_ref[m];
                    now = gen_ref[m] + $urandom_range(1, 3000);
                    gen_goal[m] = now + $urandom_range(0, 40000);
                    if (gen_goal[m] > 16'hFFFF)
                        gen_goal[m] = 16'hFFFF;
                    gen_rises[m] = 0;
                    gen_falling[m] = 1'b0;
                    gen_active[m] = 1'b1;
                end
                else if (!gen_falling[m])
                begin
                    prev = gen_level[m];
                    now = gen_level[m] + $urandom_range(0, 4000);
                    if (now > 16'hFFFF)
                        now = 16'hFFFF;
                    gen_rises[m]++;
                    if (now >= gen_goal[m] || gen_rises[m] >= 12)
                    begin
                        gen_falling[m] = 1'b1;
                        gen_left[m] = $urandom_range(1, gen_rises[m] + 2);
                        // now and then undershoot the reference
                        if (gen_ref[m] > 0 && $urandom_range(3) == 0)
                            gen_floor[m] = $urandom_range(0, gen_ref[m] - 1);
                        else
                            gen_floor[m] = gen_ref[m];
                    end
                end
                else
                begin
                    prev = gen_level[m];
                    now = gen_floor[m]
                        + (gen_level[m] - gen_floor[m]) * (gen_left[m] - 1) / gen_left[m];
                    if ($urandom_range(99) < 8 && now > 0)
                        prev = $urandom_range(0, now - 1);
                    gen_left[m]--;
                    if (gen_left[m] == 0)
                        gen_active[m] = 1'b0;
                end
                gen_level[m] = now;
                last_m = m;
            end
            push_score(m[MODEL_W-1:0], ns, now[SCORE_W-1:0], prev[SCORE_W-1:0], 1'b0, '0);
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready = 1'b0;
        end
        else
            out_ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : score_check
        interval_event_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DETECT_MODE:     cfg_mode = cfg_data[0];
                    CFG_QUICK_THRESHOLD: cfg_threshold = cfg_data[SCORE_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                want = track_interval(model_index, sample_number, score_now, score_before);
                pending_events.insert(pending_events.size(), typed_pending ? typed_want : want);
            end
            if (out_valid && out_ready)
            begin
                if (pending_events.size() == 0)
                begin
                    $display("%0t: expected no transfer, got kind %0d model %0d", $time,
                        event_kind, model_out);
                    mismatches++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    compare_field("event_kind", want.kind, event_kind);
                    compare_field("model_out", want.model, model_out);
                    compare_field("interval_start", want.start, interval_start);
                    compare_field("interval_end", want.stop, interval_end);
                    compare_field("peak_score", want.peak, peak_score);
                    compare_field("reported_score", want.rep, reported_score);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        in_valid = 1'b0;
        model_index = '0;
        sample_number = '0;
        score_now = '0;
        score_before = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int m = 0; m < NUM_MODELS_DEF; m++)
        begin
            rec_open[m] = 1'b0;
            rec_start[m] = '0;
            rec_stop[m] = '0;
            rec_peak[m] = '0;
            rec_ref[m] = '0;
            rec_rise[m] = '0;
            gen_active[m] = 1'b0;
            gen_falling[m] = 1'b0;
            gen_level[m] = 0;
            gen_sample[m] = '0;
        end

        // bell mode out of reset
        add_row(typed_row(0, 10, 0, 0, EV_NONE, 0, 0, 0, 0));
        add_row(typed_row(0, 11, 100, 0, EV_OPENED, 11, 0, 100, 0));
        add_row(typed_row(0, 12, 300, 100, EV_EXTENDED, 11, 12, 300, 0));
        add_row(typed_row(0, 13, 200, 300, EV_NONE, 0, 0, 0, 0));
        add_row(typed_row(0, 14, 0, 200, EV_COMPLETE, 11, 12, 300, 0));
        add_row(typed_row(1, 0, 16'hFFFF, 16'h8000, EV_OPENED, 0, 0, 16'hFFFF, 0));
        add_row(typed_row(1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, EV_EXTENDED,
            0, 32'hFFFF_FFFF, 16'hFFFF, 0));
        add_row(typed_row(1, 5, 16'h8000, 16'hFFFF, EV_COMPLETE,
            0, 32'hFFFF_FFFF, 16'hFFFF, 0));
        add_row(score_row(2, 20, 1000, 500));
        add_row(typed_row(2, 21, 800, 700, EV_NOT_SMOOTH, 20, 0, 1000, 0));
        // back at the reference while rough: the report wins
        add_row(score_row(3, 30, 1000, 500));
        add_row(typed_row(3, 31, 500, 400, EV_COMPLETE, 30, 0, 1000, 0));
        add_row(score_row(4, 40, 1000, 500));
        add_row(typed_row(4, 41, 300, 900, EV_ASYMMETRIC, 40, 0, 1000, 0));
        add_row(score_row(5, 50, 1000, 500));
        add_row(score_row(5, 51, 300, 200));
        // zero score with a nonzero reference leaves the interval open
        add_row(score_row(6, 60, 100, 50));
        add_row(score_row(6, 61, 0, 100));
        add_row(score_row(6, 62, 50, 60));
        add_row(cfg_row(CFG_DETECT_MODE, MODE_QUICK));
        add_row(typed_row(7, 70, 52430, 0, EV_OPENED, 70, 0, 52430, 52430));
        add_row(typed_row(7, 72, 52429, 65535, EV_CLOSED_QUICK, 70, 0, 52430, 0));
        add_row(score_row(8, 80, 60000, 0));
        add_row(cfg_row(CFG_QUICK_THRESHOLD, 16'h0000));
        add_row(score_row(9, 90, 1, 0));
        add_row(score_row(11, 110, 40000, 10));
        add_row(cfg_row(CFG_QUICK_THRESHOLD, 16'hFFFF));
        add_row(cfg_row(CFG_FIRST_SPARE, 16'h0000));
        add_row(typed_row(8, 81, 65535, 60000, EV_CLOSED_QUICK, 80, 0, 60000, 0));
        // interval opened in quick mode carries on in bell mode
        add_row(cfg_row(CFG_DETECT_MODE, MODE_BELL));
        add_row(score_row(11, 111, 45000, 40000));
        add_row(score_row(11, 112, 10, 20));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_CFG)
            begin
                drain_events();
                cfg_write(plan[r].reg_idx, plan[r].reg_data);
            end
            else
                push_score(plan[r].model, plan[r].sample, plan[r].now, plan[r].prev,
                    plan[r].kind == ROW_TYPED, plan[r].want);
        end

        drain_events();
        cfg_write(CFG_QUICK_THRESHOLD, QUICK_THRESHOLD_RST);
        idle_pct = 0;
        stall_pct = 0;
        run_traffic(250, 100, -1);
        idle_pct = 68;
        run_traffic(200, -1, 120);

        drain_events();
        cfg_write(CFG_DETECT_MODE, MODE_QUICK);
        cfg_write(CFG_QUICK_THRESHOLD, CFG_DATA_W'($urandom_range(20000, 50000)));
        cfg_write(CFG_IDX_W'($urandom_range(CFG_FIRST_SPARE, CFG_LAST_SPARE)),
            CFG_DATA_W'($urandom));
        idle_pct = 0;
        stall_pct = 68;
        run_traffic(200, -1, -1);

        drain_events();
        cfg_write(CFG_DETECT_MODE, MODE_BELL);
        idle_pct = 10;
        stall_pct = 10;
        run_traffic(200, -1, -1);

        drain_events();
        cfg_write(CFG_DETECT_MODE, MODE_QUICK);
        cfg_write(CFG_QUICK_THRESHOLD, 16'h0000);
        idle_pct = 0;
        stall_pct = 0;
        run_traffic(100, -1, -1);

        drain_events();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/bsaid_pkg.sv
src/bsaid_rec_ram.sv
src/bsaid_update.sv
src/bell_shaped_activation_interval_detector_top.sv
test/bell_shaped_activation_interval_detector_top_tb.sv
